// ===== rtl/cbs_pkg.sv =====
package cbs_pkg;

  // field widths of the stream items
  localparam int unsigned ModW     = 4;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned ReadW    = 16;
  localparam int unsigned SumW     = 24;
  localparam int unsigned StatW    = 2;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 96;
  localparam int unsigned FlagW    = 4;
  localparam int unsigned CfgIdxW  = 2;

  // operation codes (slave tuser)
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_THR_SET = 1'b1;

  // result kinds (master tuser)
  localparam logic KIND_BITMAP  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // summary status codes
  localparam logic [StatW-1:0] STAT_ACTIVE   = 2'd0;
  localparam logic [StatW-1:0] STAT_BALANCED = 2'd1;
  localparam logic [StatW-1:0] STAT_INACTIVE = 2'd2;
  localparam logic [StatW-1:0] STAT_EXTERNAL = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_STANDALONE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DIFFERENCE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FLOOR      = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_COOL_LIMIT = 2'd3;

  // configuration reset values
  localparam logic [ReadW-1:0] DIFFERENCE_RST = 16'd131;
  localparam logic [ReadW-1:0] FLOOR_RST      = 16'd52428;
  localparam logic [ReadW-1:0] COOL_LIMIT_RST = 16'd13107;

  localparam logic [ReadW-1:0] READ_MAX = 16'hFFFF;
  localparam logic [SumW-1:0]  SUM_MAX  = 24'hFFFFFF;

  // aux channels 3 to 6 carry the board sensors
  localparam logic [ChanW-1:0] CH_BOARD_FIRST = 5'd19;
  localparam logic [ChanW-1:0] CH_BOARD_LAST  = 5'd22;

  // result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  typedef struct packed {
    logic             kind;
    logic [ModW-1:0]  out_module;
    logic [ReadW-1:0] bleed_bitmap;
    logic [ReadW-1:0] next_threshold;
    logic [StatW-1:0] status;
    logic [SumW-1:0]  pack_total;
    logic [ReadW-1:0] sweep_highest;
    logic [ReadW-1:0] sweep_lowest;
    logic             sleep_request;
    logic             final_res;
  } result_t;

endpackage

// ===== rtl/cbs_cool_store.sv =====
module cbs_cool_store import cbs_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [FlagW-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [FlagW-1:0] wdata_i
);

  logic [FlagW-1:0] mem [Depth];
  logic [FlagW-1:0] raw_q;
  logic [FlagW-1:0] fwd_q;
  logic [Depth-1:0] valid_q;
  logic             rvalid_q;
  logic             hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      raw_q <= mem[raddr_i];
      fwd_q <= wdata_i;
    end
  end

  // valid bits stand for the all-hot reset; a same-cycle write is forwarded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
        hit_q    <= we_i && (waddr_i == raddr_i);
      end
    end
  end

  assign rdata_o = hit_q ? fwd_q : (rvalid_q ? raw_q : '0);

endmodule

// ===== rtl/cbs_out_fifo.sv =====
module cbs_out_fifo import cbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_a_i,
  input  logic    push_b_i,
  input  result_t item_a_i,
  input  result_t item_b_i,
  input  logic    pop_i,
  output result_t head_o,
  output logic    valid_o,
  output logic    room_o
);

  result_t             entry_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [FifoPtrW-1:0] wr_next;

  assign wr_next = wr_ptr_q + FifoPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      entry_q[wr_ptr_q] <= item_a_i;
    end
    if (push_a_i && push_b_i) begin
      entry_q[wr_next] <= item_b_i;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_a_i && push_b_i) begin
      wr_ptr_d = wr_ptr_q + FifoPtrW'(2);
      cnt_d    = cnt_d + FifoCntW'(2);
    end else if (push_a_i) begin
      wr_ptr_d = wr_next;
      cnt_d    = cnt_d + FifoCntW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + FifoPtrW'(1);
      cnt_d    = cnt_d - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  // room for the two results one item can raise
  assign room_o  = (cnt_q <= FifoCntW'(FifoDepth - 2));

endmodule

// ===== rtl/cell_balance_selector_core.sv =====
// channel | dir | handshake               | payload
// s_axis  | in  | s_axis_tvalid/tready    | tdata mod, chan, reading; tuser op; tlast sweep end
// m_axis  | out | m_axis_tvalid/tready    | tdata result fields; tuser kind; tlast last of input
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one input item per cycle while the result queue has room; the board flag memory
// read sets the two stage flow (read on transfer, read-modify-write in the work stage)
// a result passes the work stage register, then the result queue; an item that raises a
// bitmap and a summary sends two results, so sustained rate follows the output side
// reset is asynchronous; the flag memory needs no clearing pass, per-module valid
// bits stand in for the all-hot reset state
// a stalled output backs up the four-entry result queue, then the input stage
module cell_balance_selector_core import cbs_pkg::*; #(
  parameter int unsigned MODULES          = 16,
  parameter int unsigned CELLS_PER_MODULE = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [3:0] module_index, [8:4] channel, [24:9] reading, rest zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // operation
  input  logic                s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [3:0] out_module, [19:4] bleed_bitmap, [35:20] next_threshold, [37:36] status,
  // [61:38] pack_total, [77:62] sweep_highest, [93:78] sweep_lowest,
  // [94] sleep_request, [95] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // kind
  output logic                m_axis_tuser,
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [ReadW-1:0]    cfg_data_i
);

  localparam int unsigned ModAw = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam logic [ChanW-1:0] LastCell = ChanW'(CELLS_PER_MODULE - 1);

  // configuration registers
  logic             standalone_q;
  logic [ReadW-1:0] difference_q;
  logic [ReadW-1:0] floor_q;
  logic [ReadW-1:0] cool_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      standalone_q <= 1'b0;
      difference_q <= DIFFERENCE_RST;
      floor_q      <= FLOOR_RST;
      cool_limit_q <= COOL_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STANDALONE: standalone_q <= cfg_data_i[0];
        REG_DIFFERENCE: difference_q <= cfg_data_i;
        REG_FLOOR:      floor_q      <= cfg_data_i;
        REG_COOL_LIMIT: cool_limit_q <= cfg_data_i;
        default:        standalone_q <= standalone_q;
      endcase
    end
  end

  // input decode and flag read issue
  logic             in_xfer;
  logic [ModW-1:0]  in_mod;
  logic [6:0]       in_mod_ext;
  logic             in_range;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign in_mod     = s_axis_tdata[3:0];
  assign in_mod_ext = {3'b000, in_mod};
  assign in_range   = (32'(in_mod) < 32'(MODULES));

  // work stage: the item whose flag read is under way
  logic              s2_valid_q;
  logic              s2_op_q;
  logic [ModW-1:0]   s2_mod_q;
  logic [ChanW-1:0]  s2_ch_q;
  logic [ReadW-1:0]  s2_rd_q;
  logic              s2_end_q;
  logic              s2_range_q;
  logic              s2_go;
  logic              fifo_room;

  assign s2_go         = s2_valid_q && fifo_room;
  assign s_axis_tready = !s2_valid_q || s2_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s2_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s2_op_q    <= s_axis_tuser;
      s2_mod_q   <= in_mod;
      s2_ch_q    <= s_axis_tdata[8:4];
      s2_rd_q    <= s_axis_tdata[24:9];
      s2_end_q   <= s_axis_tlast;
      s2_range_q <= in_range;
    end
  end

  // board flag memory, one 4-bit entry per module
  logic [FlagW-1:0] flags_rd;
  logic [FlagW-1:0] flags_wr;
  logic             flags_we;
  logic [6:0]       s2_mod_ext;

  assign s2_mod_ext = {3'b000, s2_mod_q};

  cbs_cool_store #(
    .Depth (MODULES),
    .AddrW (ModAw)
  ) u_cool_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (in_xfer && in_range),
    .raddr_i (in_mod_ext[ModAw-1:0]),
    .rdata_o (flags_rd),
    .we_i    (flags_we),
    .waddr_i (s2_mod_ext[ModAw-1:0]),
    .wdata_i (flags_wr)
  );

  // sweep and module state
  logic [ReadW-1:0] thr_q, thr_d;
  logic [ReadW-1:0] high_q, high_d;
  logic [ReadW-1:0] low_q, low_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [ReadW-1:0] peak_q, peak_d;
  logic [ReadW-1:0] bmap_q, bmap_d;

  logic             meas;
  logic             is_cell;
  logic             is_board;
  logic [FlagW-1:0] board_bit;
  logic             cool;
  logic [ReadW-1:0] peak_base;
  logic [ReadW-1:0] bmap_base;
  logic [SumW:0]    sum_wide;
  logic [SumW-1:0]  sum_cell;
  logic [ReadW-1:0] high_cell;
  logic [ReadW-1:0] low_cell;
  logic [ReadW:0]   target;
  logic [ReadW-1:0] sum_thr;
  logic [StatW-1:0] sum_status;
  logic             sum_sleep;
  logic             emit_bmap;
  logic             emit_sum;
  result_t          res_bmap;
  result_t          res_sum;

  assign meas      = (s2_op_q == OP_MEASURE);
  assign is_cell   = meas && s2_range_q && (32'(s2_ch_q) < 32'(CELLS_PER_MODULE));
  assign is_board  = meas && s2_range_q &&
                     (s2_ch_q inside {[CH_BOARD_FIRST:CH_BOARD_LAST]});
  assign board_bit = FlagW'(1) << 2'(s2_ch_q - CH_BOARD_FIRST);
  assign cool      = &flags_rd;

  // aux 3 to 6: read-modify-write of the module's cool flags
  assign flags_we = s2_go && is_board;
  assign flags_wr = (s2_rd_q >= cool_limit_q) ? (flags_rd | board_bit)
                                              : (flags_rd & ~board_bit);

  // cell zero opens a fresh module
  assign peak_base = (s2_ch_q == '0) ? '0 : peak_q;
  assign bmap_base = (s2_ch_q == '0) ? '0 : bmap_q;

  assign sum_wide  = {1'b0, sum_q} + (SumW + 1)'(s2_rd_q);
  assign sum_cell  = sum_wide[SumW] ? SUM_MAX : sum_wide[SumW-1:0];
  assign high_cell = (s2_rd_q > high_q) ? s2_rd_q : high_q;
  assign low_cell  = (s2_rd_q < low_q) ? s2_rd_q : low_q;

  // sweep figures as they stand after this item
  logic [ReadW-1:0] high_now;
  logic [ReadW-1:0] low_now;
  logic [SumW-1:0]  sum_now;

  assign high_now = is_cell ? high_cell : high_q;
  assign low_now  = is_cell ? low_cell : low_q;
  assign sum_now  = is_cell ? sum_cell : sum_q;

  assign target = (ReadW + 1)'(low_now) + (ReadW + 1)'(difference_q);

  // end of sweep threshold decision
  always_comb begin
    sum_thr    = '0;
    sum_status = STAT_EXTERNAL;
    sum_sleep  = 1'b0;
    if (standalone_q) begin
      if (high_now > floor_q) begin
        if ((ReadW + 1)'(high_now) > target) begin
          sum_thr    = (target < (ReadW + 1)'(floor_q)) ? floor_q : target[ReadW-1:0];
          sum_status = STAT_ACTIVE;
        end else begin
          sum_status = STAT_BALANCED;
          sum_sleep  = 1'b1;
        end
      end else begin
        sum_status = STAT_INACTIVE;
        sum_sleep  = 1'b1;
      end
    end
  end

  always_comb begin
    thr_d  = thr_q;
    high_d = high_q;
    low_d  = low_q;
    sum_d  = sum_q;
    peak_d = peak_q;
    bmap_d = bmap_q;
    if (!meas) begin
      if (!standalone_q) begin
        thr_d = s2_rd_q;
      end
    end else begin
      if (is_cell) begin
        high_d = high_cell;
        low_d  = low_cell;
        sum_d  = sum_cell;
        peak_d = peak_base;
        bmap_d = bmap_base;
        // single highest cell above the threshold, board must be cool
        if (cool && (thr_q != '0) && (s2_rd_q > thr_q) && (s2_rd_q > peak_base)) begin
          peak_d = s2_rd_q;
          bmap_d = ReadW'(1) << s2_ch_q[3:0];
        end
      end
      if (s2_end_q) begin
        thr_d  = sum_thr;
        high_d = '0;
        low_d  = READ_MAX;
        sum_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      high_q <= '0;
      low_q  <= READ_MAX;
      sum_q  <= '0;
      peak_q <= '0;
      bmap_q <= '0;
    end else if (s2_go) begin
      thr_q  <= thr_d;
      high_q <= high_d;
      low_q  <= low_d;
      sum_q  <= sum_d;
      peak_q <= peak_d;
      bmap_q <= bmap_d;
    end
  end

  // result items
  assign emit_bmap = is_cell && (s2_ch_q == LastCell);
  assign emit_sum  = meas && s2_end_q;

  always_comb begin
    res_bmap              = '0;
    res_bmap.kind         = KIND_BITMAP;
    res_bmap.out_module   = s2_mod_q;
    res_bmap.bleed_bitmap = bmap_d;
    res_bmap.final_res    = !s2_end_q;

    res_sum                = '0;
    res_sum.kind           = KIND_SUMMARY;
    res_sum.next_threshold = sum_thr;
    res_sum.status         = sum_status;
    res_sum.pack_total     = sum_now;
    res_sum.sweep_highest  = high_now;
    res_sum.sweep_lowest   = low_now;
    res_sum.sleep_request  = sum_sleep;
    res_sum.final_res      = 1'b1;
  end

  result_t head;

  cbs_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (s2_go && (emit_bmap || emit_sum)),
    .push_b_i (emit_bmap && emit_sum),
    .item_a_i (emit_bmap ? res_bmap : res_sum),
    .item_b_i (res_sum),
    .pop_i    (m_axis_tvalid && m_axis_tready),
    .head_o   (head),
    .valid_o  (m_axis_tvalid),
    .room_o   (fifo_room)
  );

  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.final_res;
  assign m_axis_tdata = {1'b0, head.sleep_request, head.sweep_lowest, head.sweep_highest,
                         head.pack_total, head.status, head.next_threshold,
                         head.bleed_bitmap, head.out_module};

endmodule

// ===== rtl/cbs_checker.sv =====
module cbs_checker import cbs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser,
  input logic                m_axis_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a summary always closes the results of its input
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY) |-> m_axis_tlast)
    else $error("summary not marked last");

  // at most one cell bleeds per module
  a_bmap_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_BITMAP) |-> $onehot0(m_axis_tdata[19:4]))
    else $error("bleed bitmap has more than one cell");

  // a non-final bitmap is followed by its summary
  a_bmap_then_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == KIND_BITMAP) && !m_axis_tlast
    |=> m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY))
    else $error("summary missing after bitmap");

endmodule

bind cell_balance_selector_core cbs_checker u_cbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/cell_balance_selector_core_test.sv =====
`timescale 1ns / 100ps

module cell_balance_selector_core_test;
  import cbs_pkg::*;

  localparam int unsigned NumModules   = 16;
  localparam int unsigned NumCells     = 16;
  localparam int unsigned AuxBase      = 16;
  localparam int unsigned AuxChannels  = 8;
  localparam int unsigned SettleCycles = 8;     // plenty of margin for the result path
  localparam int unsigned HoldCycles   = 80;    // long output back-pressure stretch
  localparam int unsigned IdleLimit    = 2000;  // cycles with no transfer before giving up
  localparam int unsigned RandomItems  = 400;
  localparam int unsigned RandomResults = 60;

  // how a sweep is closed
  typedef enum int {
    END_NONE,
    END_ON_CELL,
    END_ON_AUX,
    END_ON_SPARE
  } sweep_close_e;

  // predicts the bleed bitmaps and sweep summaries and checks what the block sends
  class balance_scoreboard;
    logic                standalone;
    logic [ReadW-1:0]    difference;
    logic [ReadW-1:0]    floor_level;
    logic [ReadW-1:0]    cool_limit;
    logic [ReadW-1:0]    threshold_now;
    logic [ReadW-1:0]    highest_seen;
    logic [ReadW-1:0]    lowest_seen;
    logic [SumW-1:0]     pack_sum;
    logic [ReadW-1:0]    module_peak;
    logic [ReadW-1:0]    module_bitmap;
    logic [FlagW-1:0]    cool_flags [NumModules];
    result_t             awaited_results [$];
    int                  mismatches;

    function new();
      standalone    = 1'b0;
      difference    = DIFFERENCE_RST;
      floor_level   = FLOOR_RST;
      cool_limit    = COOL_LIMIT_RST;
      threshold_now = '0;
      highest_seen  = '0;
      lowest_seen   = READ_MAX;
      pack_sum      = '0;
      module_peak   = '0;
      module_bitmap = '0;
      mismatches    = 0;
      foreach (cool_flags[m]) cool_flags[m] = '0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [ReadW-1:0] val);
      case (idx)
        REG_STANDALONE: standalone  = val[0];
        REG_DIFFERENCE: difference  = val;
        REG_FLOOR:      floor_level = val;
        REG_COOL_LIMIT: cool_limit  = val;
        default: ;
      endcase
    endfunction

    function void take_reading(logic op, logic [ModW-1:0] mod, logic [ChanW-1:0] ch,
                               logic [ReadW-1:0] rd, logic last);
      result_t          r;
      logic [ReadW:0]   target;
      logic [SumW:0]    wide_sum;
      logic [ReadW-1:0] thr;
      logic [StatW-1:0] stat;
      logic             sleep;
      bit               cool;
      if (op == OP_THR_SET) begin
        if (!standalone) threshold_now = rd;
        return;
      end
      if (mod < NumModules) begin
        if (ch < NumCells) begin
          cool = (cool_flags[mod] == '1);
          if (ch == 0) begin
            module_peak   = '0;
            module_bitmap = '0;
          end
          wide_sum = {1'b0, pack_sum} + rd;
          pack_sum = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[SumW-1:0];
          if (rd > highest_seen) highest_seen = rd;
          if (rd < lowest_seen) lowest_seen = rd;
          if (cool && threshold_now != 0 && rd > threshold_now && rd > module_peak) begin
            module_bitmap = ReadW'(1) << ch;
            module_peak   = rd;
          end
          if (ch == NumCells - 1) begin
            r              = '0;
            r.kind         = KIND_BITMAP;
            r.out_module   = mod;
            r.bleed_bitmap = module_bitmap;
            r.final_res    = !last;
            awaited_results.push_back(r);
          end
        end else if (ch >= CH_BOARD_FIRST && ch <= CH_BOARD_LAST) begin
          cool_flags[mod][ch - CH_BOARD_FIRST] = (rd >= cool_limit);
        end
      end
      if (last) begin
        thr   = '0;
        sleep = 1'b0;
        if (standalone) begin
          target = {1'b0, lowest_seen} + difference;
          if (highest_seen > floor_level) begin
            if (highest_seen > target) begin
              thr  = (target < floor_level) ? floor_level : target[ReadW-1:0];
              stat = STAT_ACTIVE;
            end else begin
              stat  = STAT_BALANCED;
              sleep = 1'b1;
            end
          end else begin
            stat  = STAT_INACTIVE;
            sleep = 1'b1;
          end
        end else begin
          stat = STAT_EXTERNAL;
        end
        threshold_now   = thr;
        r               = '0;
        r.kind          = KIND_SUMMARY;
        r.next_threshold = thr;
        r.status        = stat;
        r.pack_total    = pack_sum;
        r.sweep_highest = highest_seen;
        r.sweep_lowest  = lowest_seen;
        r.sleep_request = sleep;
        r.final_res     = 1'b1;
        awaited_results.push_back(r);
        highest_seen = '0;
        lowest_seen  = READ_MAX;
        pack_sum     = '0;
      end
    endfunction

    function void compare_field(string name, logic [SumW-1:0] want, logic [SumW-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(result_t got, logic spare);
      result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d module %0d",
                 $time, got.kind, got.out_module);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("out_module", want.out_module, got.out_module);
      compare_field("bleed_bitmap", want.bleed_bitmap, got.bleed_bitmap);
      compare_field("next_threshold", want.next_threshold, got.next_threshold);
      compare_field("status", want.status, got.status);
      compare_field("pack_total", want.pack_total, got.pack_total);
      compare_field("sweep_highest", want.sweep_highest, got.sweep_highest);
      compare_field("sweep_lowest", want.sweep_lowest, got.sweep_lowest);
      compare_field("sleep_request", want.sleep_request, got.sleep_request);
      compare_field("final_res", want.final_res, got.final_res);
      compare_field("spare bit", '0, spare);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [3:0] module_index, [8:4] channel, [24:9] reading, rest zero
  logic [InDataW-1:0]  s_axis_tdata;
  // operation
  logic                s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [3:0] out_module, [19:4] bleed_bitmap, [35:20] next_threshold, [37:36] status,
  // [61:38] pack_total, [77:62] sweep_highest, [93:78] sweep_lowest,
  // [94] sleep_request, [95] zero
  logic [OutDataW-1:0] m_axis_tdata;
  // kind
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [ReadW-1:0]    cfg_data_i;

  balance_scoreboard sb = new();

  int  items_taken;    // input transfers so far
  int  results_seen;   // output transfers so far
  int  sender_calm;    // items left in a stretch without gaps
  int  sink_calm;      // results left in a stretch without stalls
  bit  hold_request;   // asks the result side for one long stall
  int  idle_cycles;

  cell_balance_selector_core #(
    .MODULES          (NumModules),
    .CELLS_PER_MODULE (NumCells)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // idle cycles before the next transfer, with the odd stretch of none at all
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 3);
  endfunction

  // one input transfer; entered and left at a falling edge, tvalid stays up for a
  // back-to-back item
  task automatic push_item(logic op, logic [ModW-1:0] mod, logic [ChanW-1:0] ch,
                           logic [ReadW-1:0] rd, logic last);
    int gap;
    gap = draw_gap(sender_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({rd, ch, mod});
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_reading(op, mod, ch, rd, last);
    items_taken++;
    @(negedge clk_i);
  endtask

  // stop offering, wait for every awaited result, then let items with no result drain
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ReadW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  // only called with the block idle
  task automatic program_regs(logic mode, logic [ReadW-1:0] diff, logic [ReadW-1:0] floor_v,
                              logic [ReadW-1:0] cool);
    logic [ReadW-1:0] mode_word;
    mode_word    = ReadW'($urandom);   // upper bits are don't-care, keep them moving
    mode_word[0] = mode;
    write_reg(REG_STANDALONE, mode_word);
    write_reg(REG_DIFFERENCE, diff);
    write_reg(REG_FLOOR, floor_v);
    write_reg(REG_COOL_LIMIT, cool);
    cfg_valid_i <= 1'b0;
  endtask

  // one well-formed module: cells 0 to 15 in order, then the eight aux channels,
  // with the occasional stray item thrown in among the cells
  task automatic run_module(logic [ModW-1:0] mod, int base, int spread,
                            sweep_close_e close_at);
    int v;
    for (int c = 0; c < NumCells; c++) begin
      if ($urandom_range(0, 23) == 0)
        push_item(1'($urandom), ModW'($urandom), ChanW'($urandom), ReadW'($urandom), 1'b0);
      v = base + $urandom_range(0, spread);
      if (v > READ_MAX) v = READ_MAX;
      push_item(OP_MEASURE, mod, ChanW'(c), ReadW'(v),
                close_at == END_ON_CELL && c == NumCells - 1);
    end
    for (int a = 0; a < AuxChannels; a++) begin
      if (AuxBase + a >= CH_BOARD_FIRST && AuxBase + a <= CH_BOARD_LAST) begin
        // board sensors mostly cool so that balancing gets a chance next sweep
        if (sb.cool_limit != 0 && $urandom_range(0, 9) == 0)
          v = $urandom_range(0, sb.cool_limit - 1);
        else
          v = $urandom_range(sb.cool_limit, READ_MAX);
      end else begin
        v = $urandom_range(0, READ_MAX);
      end
      push_item(OP_MEASURE, mod, ChanW'(AuxBase + a), ReadW'(v),
                close_at == END_ON_AUX && a == AuxChannels - 1);
    end
  endtask

  // consecutive sweeps over one small group of modules, so that the cool flags and
  // the threshold of one sweep act on the next
  task automatic run_sweeps(int count);
    int           base;
    int           spread;
    int           nmods;
    int           first_mod;
    sweep_close_e close_at;
    first_mod = $urandom_range(0, NumModules - 1);
    nmods     = $urandom_range(1, 3);
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: begin
          base   = 0;
          spread = READ_MAX;
        end
        1: begin
          base   = $urandom_range(0, READ_MAX);
          spread = $urandom_range(0, 2);
        end
        2: begin
          base   = $urandom_range(0, 2000);
          spread = $urandom_range(0, 500);
        end
        default: begin
          base   = $urandom_range(30000, READ_MAX);
          spread = $urandom_range(0, 3000);
        end
      endcase
      // external control loads a threshold ahead of each sweep
      if (!sb.standalone)
        push_item(OP_THR_SET, ModW'($urandom), ChanW'($urandom),
                  ReadW'(base + $urandom_range(0, spread)), 1'($urandom));
      case ($urandom_range(0, 5))
        0:       close_at = END_ON_CELL;
        1:       close_at = END_ON_SPARE;
        default: close_at = END_ON_AUX;
      endcase
      for (int k = 0; k < nmods; k++)
        run_module(ModW'(first_mod + k), base, spread,
                   (k == nmods - 1) ? close_at : END_NONE);
      if (close_at == END_ON_SPARE)
        push_item(OP_MEASURE, ModW'($urandom), ChanW'($urandom_range(24, 31)),
                  ReadW'($urandom), 1'b1);
    end
  endtask

  // result side: random stalls, one long hold when asked, every transfer checked
  initial begin : result_sink
    int      stall;
    result_t got;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = draw_gap(sink_calm);
      if (hold_request) begin
        hold_request = 1'b0;
        stall        = HoldCycles;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.kind           = m_axis_tuser;
      got.out_module     = m_axis_tdata[3:0];
      got.bleed_bitmap   = m_axis_tdata[19:4];
      got.next_threshold = m_axis_tdata[35:20];
      got.status         = m_axis_tdata[37:36];
      got.pack_total     = m_axis_tdata[61:38];
      got.sweep_highest  = m_axis_tdata[77:62];
      got.sweep_lowest   = m_axis_tdata[93:78];
      got.sleep_request  = m_axis_tdata[94];
      got.final_res      = m_axis_tlast;
      sb.match_result(got, m_axis_tdata[OutDataW-1]);
      results_seen++;
      @(negedge clk_i);
    end
  end

  // watchdog on transfers of any kind
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int random_from;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_MEASURE;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_STANDALONE;
    cfg_data_i    = '0;
    items_taken   = 0;
    results_seen  = 0;
    sender_calm   = 0;
    sink_calm     = 0;
    hold_request  = 1'b0;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // external control, reset values
    program_regs(1'b0, DIFFERENCE_RST, FLOOR_RST, COOL_LIMIT_RST);
    // empty sweep closed by an unused channel
    push_item(OP_MEASURE, ModW'(0), ChanW'(31), READ_MAX, 1'b1);
    // threshold command, its sweep end and addressing ignored
    push_item(OP_THR_SET, ModW'(15), ChanW'(31), ReadW'(16'h8000), 1'b1);
    // board sensors of module 15 cool, outer aux channels without effect
    for (int a = CH_BOARD_FIRST; a <= CH_BOARD_LAST; a++)
      push_item(OP_MEASURE, ModW'(15), ChanW'(a), READ_MAX, 1'b0);
    push_item(OP_MEASURE, ModW'(15), ChanW'(AuxBase), ReadW'(0), 1'b0);
    push_item(OP_MEASURE, ModW'(15), ChanW'(AuxBase + AuxChannels - 1), READ_MAX, 1'b0);
    // first of two equal maxima wins
    push_item(OP_MEASURE, ModW'(15), ChanW'(0), ReadW'(0), 1'b0);
    push_item(OP_MEASURE, ModW'(15), ChanW'(3), READ_MAX, 1'b0);
    push_item(OP_MEASURE, ModW'(15), ChanW'(7), READ_MAX, 1'b0);
    push_item(OP_MEASURE, ModW'(15), ChanW'(15), ReadW'(16'h8001), 1'b0);
    // cell zero restarts the module, bitmap and summary from one item
    push_item(OP_MEASURE, ModW'(15), ChanW'(0), ReadW'(16'h9000), 1'b0);
    push_item(OP_MEASURE, ModW'(15), ChanW'(15), ReadW'(16'h8000), 1'b1);
    // hot module never bleeds
    push_item(OP_MEASURE, ModW'(0), ChanW'(0), READ_MAX, 1'b0);
    push_item(OP_MEASURE, ModW'(0), ChanW'(24), READ_MAX, 1'b0);
    push_item(OP_MEASURE, ModW'(0), ChanW'(15), ReadW'(0), 1'b1);
    settle_block();

    // standalone: threshold command ignored, then active twice, balanced, inactive
    program_regs(1'b1, DIFFERENCE_RST, FLOOR_RST, COOL_LIMIT_RST);
    push_item(OP_THR_SET, ModW'(15), ChanW'(0), ReadW'(1234), 1'b0);
    push_item(OP_MEASURE, ModW'(15), ChanW'(0), READ_MAX, 1'b0);
    push_item(OP_MEASURE, ModW'(15), ChanW'(15), ReadW'(0), 1'b1);
    push_item(OP_MEASURE, ModW'(15), ChanW'(0), ReadW'(52429), 1'b0);
    push_item(OP_MEASURE, ModW'(15), ChanW'(15), ReadW'(52000), 1'b1);
    push_item(OP_MEASURE, ModW'(15), ChanW'(15), ReadW'(60000), 1'b1);
    push_item(OP_MEASURE, ModW'(15), ChanW'(15), ReadW'(100), 1'b1);
    settle_block();

    // pack sum saturation: more full-scale cells than one pass over the chain holds
    for (int i = 0; i < (NumModules + 1) * NumCells; i++)
      push_item(OP_MEASURE, ModW'(i / NumCells), ChanW'(i % NumCells), READ_MAX,
                i == (NumModules + 1) * NumCells - 1);
    settle_block();

    random_from = items_taken;

    // extreme settings
    program_regs(1'b1, '0, '0, '0);
    run_sweeps(3);
    settle_block();
    program_regs(1'b1, READ_MAX, READ_MAX, READ_MAX);
    run_sweeps(2);
    settle_block();

    // output held off for a long stretch while cell 15 items keep coming,
    // so the result queue fills and the input stalls
    program_regs(1'b1, DIFFERENCE_RST, ReadW'(1000), COOL_LIMIT_RST);
    run_sweeps(2);
    hold_request = 1'b1;
    sender_calm  = 40;
    repeat (24)
      push_item(OP_MEASURE, ModW'($urandom), ChanW'(NumCells - 1), ReadW'($urandom),
                1'($urandom));
    settle_block();

    // random settings between phases
    while (items_taken - random_from < RandomItems || results_seen < RandomResults) begin
      program_regs(1'($urandom),
                   ($urandom_range(0, 3) == 0) ? ReadW'($urandom) :
                                                 ReadW'($urandom_range(0, 600)),
                   ReadW'($urandom), ReadW'($urandom_range(0, 40000)));
      run_sweeps($urandom_range(1, 3));
      settle_block();
    end

    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cbs_pkg.sv
rtl/cbs_cool_store.sv
rtl/cbs_out_fifo.sv
rtl/cell_balance_selector_core.sv
rtl/cbs_checker.sv
tb/cell_balance_selector_core_test.sv
